@@ rtl/core/fsr_pkg.sv @@
// Package for the fraction subtract and reduce block.
// Holds the port word types, field widths and the back end state codes.
// No dependencies.
package fsr_pkg;

   // Width of each input field on the ports.
   localparam int FIELD_BITS = 16;
   // Widths of the result fields.
   localparam int NUM_BITS = 33;
   localparam int DEN_BITS = 31;
   // Width used to trim results to the field widths.
   localparam int TRIM_BITS = 80;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] left_numerator;
      logic signed [FIELD_BITS-1:0] left_denominator;
      logic signed [FIELD_BITS-1:0] right_numerator;
      logic signed [FIELD_BITS-1:0] right_denominator;
   } fsr_req_type;

   typedef struct packed {
      logic signed [NUM_BITS-1:0] diff_numerator;
      logic [DEN_BITS-1:0]        diff_denominator;
      logic                       zero_denominator;
   } fsr_rsp_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_GCD1,
      BK_DIV1,
      BK_MUL_DEN,
      BK_MUL_A,
      BK_MUL_C,
      BK_SUB,
      BK_GCD2,
      BK_DIV2,
      BK_OUT
   } fsr_state_type;

endpackage

@@ rtl/core/fsr_front.sv @@
// Front end of the fraction subtract and reduce block.
// Classifies an incoming word and moves the denominator signs into the numerators.
// Depends on fsr_pkg.
module fsr_front
   import fsr_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   localparam int EW = 4 * VALUE_BITS + 3
) (
   input  fsr_req_type   req_data,
   output logic [EW-1:0] entry
);

   localparam int XW = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
   localparam int VB = VALUE_BITS;

   logic [XW-1:0]        a_x, b_x, c_x, d_x;
   logic signed [VB:0]   a_s, b_s, c_s, d_s;
   logic signed [VB:0]   a_fix, c_fix, b_mag, d_mag;
   logic                 zero_den;

   // Fields are used through their low bits, sign extended from the top one.
   always_comb begin
      a_x = XW'($unsigned(req_data.left_numerator));
      b_x = XW'($unsigned(req_data.left_denominator));
      c_x = XW'($unsigned(req_data.right_numerator));
      d_x = XW'($unsigned(req_data.right_denominator));
      a_s = {a_x[VB-1], a_x[VB-1:0]};
      b_s = {b_x[VB-1], b_x[VB-1:0]};
      c_s = {c_x[VB-1], c_x[VB-1:0]};
      d_s = {d_x[VB-1], d_x[VB-1:0]};
   end

   // A negative denominator flips the sign of its numerator.
   always_comb begin
      zero_den = (b_s == '0) || (d_s == '0);
      a_fix    = b_s[VB] ? -a_s : a_s;
      c_fix    = d_s[VB] ? -c_s : c_s;
      b_mag    = b_s[VB] ? -b_s : b_s;
      d_mag    = d_s[VB] ? -d_s : d_s;
      entry    = {zero_den, a_fix, c_fix, b_mag[VB-1:0], d_mag[VB-1:0]};
   end

endmodule

@@ rtl/core/fsr_queue.sv @@
// Two entry queue between the front and back ends.
// Self-contained; no package dependency.
module fsr_queue #(
   parameter int DATA_BITS = 67
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   input  logic                 pop,
   output logic                 full,
   output logic                 not_empty,
   output logic [DATA_BITS-1:0] head
);

   logic [DATA_BITS-1:0] slot_ff [2];
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic [1:0]           count_ff, count_in;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign head      = slot_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/core/fsr_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Self-contained; no package dependency.
module fsr_div #(
   parameter int WIDTH = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);

   localparam int CW = $clog2(WIDTH + 1);

   logic [WIDTH:0]   rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dsr_ff, dsr_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   rem_sh, diff;

   assign done     = done_ff;
   assign quotient = quo_ff;

   // One shift and trial subtract each cycle.
   always_comb begin
      rem_sh  = {rem_ff[WIDTH-1:0], quo_ff[WIDTH-1]};
      diff    = rem_sh - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dsr_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[WIDTH]) begin
            rem_in = rem_sh;
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end else begin
            rem_in = diff;
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CW'(WIDTH - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

endmodule

@@ rtl/core/fsr_back.sv @@
// Back end of the fraction subtract and reduce block.
// Runs the GCD loops, dividers and multiplier, and holds the result word.
// Depends on fsr_pkg and fsr_div.
module fsr_back
   import fsr_pkg::*;
#(
   parameter int VALUE_BITS = 16,
   localparam int EW = 4 * VALUE_BITS + 3
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  logic [EW-1:0] q_data,
   output logic          q_pop,
   output logic          rsp_valid,
   output fsr_rsp_type   rsp_data,
   input  logic          rsp_stall
);

   localparam int VB = VALUE_BITS;
   localparam int NW = 2 * VALUE_BITS + 2;
   localparam int KW = $clog2(NW + 1);

   fsr_state_type state_ff, state_in;

   logic signed [VB:0]     a_ff, a_in, c_ff, c_in;
   logic [VB-1:0]          bm_ff, bm_in, dm_ff, dm_in;
   logic [VB-1:0]          lb_ff, lb_in, ld_ff, ld_in;
   logic [NW-1:0]          gx_ff, gx_in, gy_ff, gy_in;
   logic [KW-1:0]          gk_ff, gk_in;
   logic [NW-1:0]          den_ff, den_in;
   logic signed [NW-1:0]   p1_ff, p1_in, p2_ff, p2_in;
   logic signed [NW-1:0]   num_ff, num_in;
   fsr_rsp_type            res_ff, res_in;
   logic                   out_valid_ff, out_valid_in;
   fsr_rsp_type            out_data_ff, out_data_in;

   logic                   div_start;
   logic [NW-1:0]          div0_a, div0_b, div1_a, div1_b, quo0, quo1;
   logic                   div_done, div1_done;
   logic signed [VB:0]     mul_x, mul_y;
   logic signed [NW-1:0]   product;
   logic                   gcd_done;
   logic [NW-1:0]          gcd_val;
   logic [NW-1:0]          num_mag;
   logic signed [TRIM_BITS-1:0] num_wide;
   logic [TRIM_BITS-1:0]   den_wide;
   logic signed [NW-1:0]   num_red;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Two dividers start together, both dividing by the GCD; u_div1 takes the denominator.
   fsr_div #(.WIDTH(NW)) u_div0 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div0_a),
      .divisor  (div0_b),
      .done     (div_done),
      .quotient (quo0)
   );

   fsr_div #(.WIDTH(NW)) u_div1 (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div1_a),
      .divisor  (div1_b),
      .done     (div1_done),
      .quotient (quo1)
   );

   // Shared signed multiplier, operands picked by state.
   always_comb begin
      unique case (state_ff)
         BK_MUL_A: begin
            mul_x = a_ff;
            mul_y = $signed({1'b0, ld_ff});
         end
         BK_MUL_C: begin
            mul_x = c_ff;
            mul_y = $signed({1'b0, lb_ff});
         end
         default: begin
            mul_x = $signed({1'b0, lb_ff});
            mul_y = $signed({1'b0, dm_ff});
         end
      endcase
      product = mul_x * mul_y;
   end

   // End test and result of the GCD loop, with the shared factors of two shifted back in.
   always_comb begin
      gcd_done = (gx_ff == '0) || (gy_ff == '0);
      gcd_val  = (gx_ff | gy_ff) << gk_ff;
   end

   // Numerator magnitude, signed reduced numerator and trimming to the field widths.
   always_comb begin
      num_mag  = num_ff[NW-1] ? NW'(-num_ff) : NW'(num_ff);
      num_red  = num_ff[NW-1] ? -$signed(quo0) : $signed(quo0);
      num_wide = TRIM_BITS'(num_red);
      den_wide = TRIM_BITS'(quo1);
   end

   // Sequencer: next state and data path control.
   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      bm_in        = bm_ff;
      dm_in        = dm_ff;
      lb_in        = lb_ff;
      ld_in        = ld_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      gk_in        = gk_ff;
      den_in       = den_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      num_in       = num_ff;
      res_in       = res_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_data_in  = out_data_ff;
      q_pop        = 1'b0;
      div_start    = 1'b0;
      div0_a       = NW'(bm_ff);
      div0_b       = gcd_val;
      div1_a       = NW'(dm_ff);
      div1_b       = gcd_val;

      unique case (state_ff)
         BK_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               {res_in.zero_denominator, a_in, c_in, bm_in, dm_in} = q_data;
               gx_in = NW'(q_data[2*VB-1:VB]);
               gy_in = NW'(q_data[VB-1:0]);
               gk_in = '0;
               res_in.diff_numerator   = '0;
               res_in.diff_denominator = '0;
               if (q_data[EW-1]) begin
                  state_in = BK_OUT;
               end else begin
                  state_in = BK_GCD1;
               end
            end
         end
         BK_GCD1, BK_GCD2: begin
            if (gcd_done) begin
               div_start = 1'b1;
               if (state_ff == BK_GCD2) begin
                  div0_a   = num_mag;
                  div1_a   = den_ff;
                  state_in = BK_DIV2;
               end else begin
                  state_in = BK_DIV1;
               end
            end else if (!gx_ff[0] && !gy_ff[0]) begin
               gx_in = gx_ff >> 1;
               gy_in = gy_ff >> 1;
               gk_in = gk_ff + 1'b1;
            end else if (!gx_ff[0]) begin
               gx_in = gx_ff >> 1;
            end else if (!gy_ff[0]) begin
               gy_in = gy_ff >> 1;
            end else if (gx_ff >= gy_ff) begin
               gx_in = (gx_ff - gy_ff) >> 1;
            end else begin
               gy_in = (gy_ff - gx_ff) >> 1;
            end
         end
         BK_DIV1: begin
            if (div_done && div1_done) begin
               lb_in    = quo0[VB-1:0];
               ld_in    = quo1[VB-1:0];
               state_in = BK_MUL_DEN;
            end
         end
         BK_MUL_DEN: begin
            den_in   = NW'($unsigned(product));
            state_in = BK_MUL_A;
         end
         BK_MUL_A: begin
            p1_in    = product;
            state_in = BK_MUL_C;
         end
         BK_MUL_C: begin
            p2_in    = product;
            state_in = BK_SUB;
         end
         BK_SUB: begin
            num_in = p1_ff - p2_ff;
            if (p1_ff == p2_ff) begin
               res_in.diff_numerator   = '0;
               res_in.diff_denominator = DEN_BITS'(1);
               state_in = BK_OUT;
            end else begin
               gx_in    = (p1_ff > p2_ff) ? NW'(p1_ff - p2_ff) : NW'(p2_ff - p1_ff);
               gy_in    = den_ff;
               gk_in    = '0;
               state_in = BK_GCD2;
            end
         end
         BK_DIV2: begin
            if (div_done && div1_done) begin
               res_in.diff_numerator   = num_wide[NUM_BITS-1:0];
               res_in.diff_denominator = den_wide[DEN_BITS-1:0];
               state_in = BK_OUT;
            end
         end
         BK_OUT: begin
            if (!out_valid_ff || !rsp_stall) begin
               out_valid_in = 1'b1;
               out_data_in  = res_ff;
               state_in     = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Data path registers.
   always_ff @(posedge clock) begin
      a_ff        <= a_in;
      c_ff        <= c_in;
      bm_ff       <= bm_in;
      dm_ff       <= dm_in;
      lb_ff       <= lb_in;
      ld_ff       <= ld_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      gk_ff       <= gk_in;
      den_ff      <= den_in;
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      num_ff      <= num_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
   end

endmodule

@@ rtl/core/fraction_subtract_reduce.sv @@
// Fraction subtract and reduce, top level.
// Joins front end, queue and back end; depends on fsr_pkg and the fsr_* modules.
//
// Each request word carries a/b and c/d and yields one response word with (a/b)-(c/d) in
// lowest terms, the denominator positive, 0/1 for a zero difference, and 0/0 with
// zero_denominator set when b or d is zero. A zero-denominator word passes the queue and
// goes from the idle state straight to the output state. Otherwise an item runs two
// binary GCD loops of one step per cycle (their lengths set by the operand values), two
// passes of the restoring dividers, and the states MUL_DEN, MUL_A, MUL_C and SUB on the
// shared multiplier and subtractor. A zero difference skips the second GCD loop and
// division. The front end and a two word queue take new requests while the back end
// works, so up to two requests wait behind the one in progress.
module fraction_subtract_reduce
   import fsr_pkg::*;
#(
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  fsr_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output fsr_rsp_type rsp_data
);

   localparam int EW = 4 * VALUE_BITS + 3;

   logic [EW-1:0] entry, head;
   logic          q_full, q_valid, q_pop;

   assign req_stall = q_full;

   // Classify the incoming word.
   fsr_front #(.VALUE_BITS(VALUE_BITS)) u_front (
      .req_data (req_data),
      .entry    (entry)
   );

   // Decoupling queue.
   fsr_queue #(.DATA_BITS(EW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid && !q_full),
      .push_data (entry),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_valid),
      .head      (head)
   );

   // Arithmetic back end.
   fsr_back #(.VALUE_BITS(VALUE_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_data    (head),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall)
   );

   // An error word carries an all-zero fraction.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.zero_denominator |->
         rsp_data.diff_numerator == '0 && rsp_data.diff_denominator == '0)
      else $error("error word with nonzero fraction");

   // A good word always has a nonzero denominator.
   a_den_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.zero_denominator |-> rsp_data.diff_denominator != '0)
      else $error("zero denominator on a good word");

   // No response word is pending right after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

@@ bench/tb_top.sv @@
// Testbench for the fraction subtract and reduce block.
// Drives request words from a queue, predicts each difference in lowest terms and checks
// every response word; depends on fsr_pkg and fraction_subtract_reduce.
`timescale 1ns / 1ps

module tb_top;
   import fsr_pkg::*;

   localparam int VALUE_BITS = 16;
   localparam int IDLE_LIMIT = 20000;
   localparam int RANDOM_WORDS = 950;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   fsr_req_type req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   fsr_rsp_type rsp_data;

   fsr_req_type pending_words[$];
   fsr_rsp_type expected_diffs[$];
   int          error_count;
   int          quiet_cycles;
   bit          calm_mode;
   bit          hold_sender;
   bit          stimulus_done;
   bit          req_waiting;

   fraction_subtract_reduce #(.VALUE_BITS(VALUE_BITS)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Euclid on unsigned 64-bit values.
   function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
      logic [63:0] r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // Predicts (a/b)-(c/d) in lowest terms with 64-bit wrapping arithmetic.
   function automatic fsr_rsp_type reduce_difference(fsr_req_type w);
      fsr_rsp_type res;
      logic signed [63:0] a, b, c, d, num;
      logic [63:0] bm, dm, g, lb, ld, den, nm, h;
      a = 64'(w.left_numerator);
      b = 64'(w.left_denominator);
      c = 64'(w.right_numerator);
      d = 64'(w.right_denominator);
      res = '0;
      if (b == 0 || d == 0) begin
         res.zero_denominator = 1'b1;
         return res;
      end
      bm = b[63] ? -b : b;
      dm = d[63] ? -d : d;
      if (b[63]) a = -a;
      if (d[63]) c = -c;
      g = gcd64(bm, dm);
      lb = bm / g;
      ld = dm / g;
      den = lb * dm;
      num = a * $signed(ld) - c * $signed(lb);
      if (num == 0) begin
         res.diff_denominator = 1;
         return res;
      end
      nm = num[63] ? -num : num;
      h = gcd64(nm, den);
      nm = nm / h;
      den = den / h;
      res.diff_numerator = num[63] ? NUM_BITS'(-nm) : NUM_BITS'(nm);
      res.diff_denominator = DEN_BITS'(den);
      return res;
   endfunction

   task automatic report_mismatch(string what, fsr_rsp_type got, fsr_rsp_type want);
      $display("mismatch %s: got %0d/%0d z%0b want %0d/%0d z%0b", what,
               got.diff_numerator, got.diff_denominator, got.zero_denominator,
               want.diff_numerator, want.diff_denominator, want.zero_denominator);
      error_count++;
   endtask

   function automatic fsr_req_type make_word(int a, int b, int c, int d);
      fsr_req_type w;
      w.left_numerator = 16'(a);
      w.left_denominator = 16'(b);
      w.right_numerator = 16'(c);
      w.right_denominator = 16'(d);
      return w;
   endfunction

   // Half small values so reduction and signs get exercised, the rest extremes or full-range words.
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 3))
         0: return 16'($urandom_range(0, 24)) - 16'd12;
         1: return 16'($urandom_range(0, 400)) - 16'd200;
         2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   // Driver: presents the oldest pending word, idling at random.
   // A word stalled at the last rising edge is held until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_waiting) begin
         if (pending_words.size() > 0 && !hold_sender &&
             (calm_mode || $urandom_range(0, 99) >= 20)) begin
            req_valid <= 1'b1;
            req_data <= pending_words.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_stall <= calm_mode ? 1'b0 : ($urandom_range(0, 99) < 20);
   end

   // Monitor: predicts on each accepted request, checks each accepted response and watches for idling.
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
         req_waiting <= 1'b0;
      end else begin
         req_waiting <= req_valid && req_stall;
         if (req_valid && !req_stall)
            expected_diffs.push_back(reduce_difference(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_diffs.size() == 0) begin
               report_mismatch("unexpected word", rsp_data, '0);
            end else if (rsp_data !== expected_diffs[0]) begin
               report_mismatch("field", rsp_data, expected_diffs[0]);
               void'(expected_diffs.pop_front());
            end else begin
               void'(expected_diffs.pop_front());
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   initial begin
      int n;
      error_count = 0;
      calm_mode = 1'b0;
      hold_sender = 1'b0;
      stimulus_done = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      rsp_stall = 1'b0;
      req_data = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed words: extremes, zero denominators, zero difference, negative denominators.
      pending_words.push_back(make_word(1, 2, 1, 3));
      pending_words.push_back(make_word(1, 0, 1, 3));
      pending_words.push_back(make_word(1, 3, 1, 0));
      pending_words.push_back(make_word(0, 0, 0, 0));
      pending_words.push_back(make_word(2, 4, 1, 2));
      pending_words.push_back(make_word(0, 5, 0, -7));
      pending_words.push_back(make_word(3, -4, 5, 6));
      pending_words.push_back(make_word(-3, -4, -5, -6));
      pending_words.push_back(make_word(32767, 1, -32768, 1));
      pending_words.push_back(make_word(-32768, 1, 32767, 1));
      pending_words.push_back(make_word(-32768, -32768, 32767, 32767));
      pending_words.push_back(make_word(1, 32767, 1, -32768));
      pending_words.push_back(make_word(-32768, 32767, 32767, -32768));
      pending_words.push_back(make_word(-32768, -1, -32768, 1));
      pending_words.push_back(make_word(32767, 32766, 32765, 32767));
      pending_words.push_back(make_word(-1, -1, -1, -1));
      pending_words.push_back(make_word(6, 9, 4, 6));

      // Let everything drain, then pause the sender until no result is outstanding.
      wait (pending_words.size() == 0);
      hold_sender = 1'b1;
      wait (!req_valid);
      wait (expected_diffs.size() == 0);
      @(negedge clock);
      hold_sender = 1'b0;

      for (n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 16 == 0) wait (pending_words.size() < 8);
         calm_mode = (n >= 300 && n < 400);
         if ($urandom_range(0, 19) == 0)
            pending_words.push_back(make_word(pick_value(), $urandom_range(0, 1) ? 0 :
                                    pick_value(), pick_value(), 0));
         else
            pending_words.push_back(make_word(pick_value(), pick_value() | 16'd1 <<
                                    $urandom_range(0, 15), pick_value(), pick_value() |
                                    16'd1 << $urandom_range(0, 15)));
      end
      calm_mode = 1'b0;
      wait (pending_words.size() == 0 && !req_valid);
      wait (expected_diffs.size() == 0);
      repeat (200) @(posedge clock);
      if (error_count == 0 && expected_diffs.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
